// ----- design/askf_pkg.sv -----
// Shared types and constants for the adaptive scalar Kalman filter.
package askf_pkg;

    // Fixed-point formats of the variance path
    localparam int VF        = 16;          // fraction bits of P, Q, R, K
    localparam int VAR_W     = 18;          // stored width of P, Q, R
    localparam int NOISE_W   = 17;          // width of the noise bound registers
    localparam int DEV_W     = 16;          // width of jump and ramp thresholds
    localparam int CFG_W     = 17;          // config data width (widest register)
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = VF + 1;      // K and alpha, up to 1.0
    localparam int DIV_NUM_W = VAR_W + 1;   // P + Q
    localparam int DIV_DEN_W = VAR_W + 2;   // P + Q + R

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << VF;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_JUMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_FULL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Q_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Q_MAX       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R_MIN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_R_MAX       = 3'd6;

    // Config reset values
    localparam logic [DEV_W-1:0]   MAX_JUMP_RST    = 16'd3840;
    localparam logic [DEV_W-1:0]   ADAPT_START_RST = 16'd51;
    localparam logic [DEV_W-1:0]   ADAPT_FULL_RST  = 16'd1152;
    localparam logic [NOISE_W-1:0] Q_MIN_RST       = 17'd262;
    localparam logic [NOISE_W-1:0] Q_MAX_RST       = 17'd19661;
    localparam logic [NOISE_W-1:0] R_MIN_RST       = 17'd5243;
    localparam logic [NOISE_W-1:0] R_MAX_RST       = 17'd52429;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEV,
        ST_RAMP,
        ST_DIV_A,
        ST_SQ,
        ST_QB,
        ST_RB,
        ST_RD,
        ST_PN,
        ST_DIV_K,
        ST_K_WAIT,
        ST_EST,
        ST_VAR,
        ST_PUPD,
        ST_DONE
    } askf_state_t;

    typedef enum logic [2:0] {
        MUL_ALPHA,
        MUL_QSPAN,
        MUL_RSPAN,
        MUL_GAIN,
        MUL_VAR
    } askf_mul_sel_t;

    typedef struct packed {
        logic          load_in;
        logic          load_dev;
        logic          alpha_one;
        logic          div_alpha;
        logic          div_k;
        logic          load_alpha;
        logic          mul_en;
        askf_mul_sel_t mul_sel;
        logic          load_a2;
        logic          load_q;
        logic          load_r;
        logic          load_pn;
        logic          load_k;
        logic          load_est;
        logic          load_p;
        logic          load_out;
    } askf_cmd_t;

    typedef struct packed {
        logic adapt;
        logic ramp_full;
        logic div_done;
        logic out_free;
    } askf_status_t;

endpackage

// ----- design/adaptive_scalar_kalman_filter_core.sv -----
// Top level of the adaptive scalar Kalman filter core.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ----------------------------------------
//  input     in_valid / in_ready    sample (signed Q8.8), restart
//  output    out_valid / out_ready  estimate (signed Q8.8), spike_rejected
//  config    cfg_we (no stall)      cfg_index, cfg_data (17 bits)
//
//  One sample at a time. The result is loaded after the gain K division and, when the
//  deviation exceeds adapt_start, after the noise blend; the ramp alpha division runs
//  only when the ramp does not saturate. Both use the same iterative divider.
//  in_ready is high only while the sequencer is idle between samples; the result sits in an
//  output register, and a stalled result holds the sequencer in its last step.
//  Reset (rst_n, async, active low) loads the config defaults, estimate 25.0,
//  P = 0, Q = q_min and R = r_max.
module adaptive_scalar_kalman_filter_core
    import askf_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int SAMPLE_FRAC_BITS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // config write port
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    // sample input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           restart,
    // filtered output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] estimate,
    output logic                           spike_rejected
);

    askf_cmd_t    cmd;
    askf_status_t status;

    // Sequencer: walks deviation, ramp, noise blend, gain and update steps
    askf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, filter state, config and the output register
    askf_dpath #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (sample),
        .restart        (restart),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .estimate       (estimate),
        .spike_rejected (spike_rejected),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// ----- design/askf_div.sv -----
// Restoring divider: quotient floor(num * 2^VF / den), one bit per cycle.
module askf_div
    import askf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [GAIN_W-1:0]    quot
);

    localparam int CNT_W = $clog2(VF);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [GAIN_W-1:0]    quot_reg;

    logic                 first_ge;
    logic [DIV_DEN_W-1:0] first_rem;
    logic [DIV_DEN_W:0]   rem_dbl;
    logic                 step_ge;
    logic [DIV_DEN_W-1:0] step_rem;

    // Caller guarantees num < 2 * den, so the quotient fits VF + 1 bits.
    always_comb
    begin
        first_ge  = DIV_DEN_W'(num) >= den;
        first_rem = first_ge ? DIV_DEN_W'(num) - den : DIV_DEN_W'(num);
        rem_dbl   = {rem_reg, 1'b0};
        step_ge   = rem_dbl >= {1'b0, den_reg};
        step_rem  = step_ge ? DIV_DEN_W'(rem_dbl - {1'b0, den_reg})
                            : DIV_DEN_W'(rem_dbl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(VF - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= first_rem;
            quot_reg <= {{VF{1'b0}}, first_ge};
        end
        else if (busy_reg)
        begin
            rem_reg  <= step_rem;
            quot_reg <= {quot_reg[GAIN_W-2:0], step_ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- design/askf_dpath.sv -----
// Datapath: config registers, filter state, shared multiplier and divider, output register.
module askf_dpath
    import askf_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int SAMPLE_FRAC_BITS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           restart,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] estimate,
    output logic                           spike_rejected,
    input  askf_cmd_t                      cmd,
    output askf_status_t                   status
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int DIFF_W = SW + 1;
    localparam int MB_W   = (DIFF_W > DIV_NUM_W + 1) ? DIFF_W : DIV_NUM_W + 1;
    localparam int PROD_W = MB_W + GAIN_W + 1;
    localparam int CMP_W  = (DIFF_W > DEV_W) ? DIFF_W : DEV_W;
    localparam logic [SW-1:0] EST_INIT = SW'(64'd25 << SAMPLE_FRAC_BITS);

    // Config
    logic [DEV_W-1:0]   max_jump_reg;
    logic [DEV_W-1:0]   adapt_start_reg;
    logic [DEV_W-1:0]   adapt_full_reg;
    logic [NOISE_W-1:0] q_min_reg;
    logic [NOISE_W-1:0] q_max_reg;
    logic [NOISE_W-1:0] r_min_reg;
    logic [NOISE_W-1:0] r_max_reg;

    // Filter state
    logic signed [SW-1:0] est_reg;
    logic [VAR_W-1:0]     p_reg;
    logic [VAR_W-1:0]     q_reg;
    logic [VAR_W-1:0]     r_reg;

    // Per-sample working registers
    logic signed [SW-1:0]     meas_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [DEV_W-1:0]         dev_reg;
    logic                     spike_reg;
    logic [GAIN_W-1:0]        alpha_reg;
    logic [GAIN_W-1:0]        a2_reg;
    logic [DIV_NUM_W-1:0]     pn_reg;
    logic [DIV_DEN_W-1:0]     den_reg;
    logic [GAIN_W-1:0]        k_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Output register
    logic                 out_valid_reg;
    logic signed [SW-1:0] out_est_reg;
    logic                 out_spike_reg;

    logic signed [DIFF_W-1:0] diff_raw;
    logic [DIFF_W-1:0]        dev_raw;
    logic                     spike_now;
    logic [DEV_W-1:0]         ramp_num;
    logic [DEV_W-1:0]         ramp_den;
    logic                     q_up;
    logic                     r_down;
    logic [NOISE_W-1:0]       q_span;
    logic [NOISE_W-1:0]       r_span;
    logic [NOISE_W-1:0]       blend_step;
    logic [NOISE_W-1:0]       q_new;
    logic [NOISE_W-1:0]       r_new;
    logic [GAIN_W-1:0]        mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     div_start;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     div_done;
    logic [GAIN_W-1:0]        div_quot;

    // Deviation and spike test
    always_comb
    begin
        diff_raw  = DIFF_W'(meas_reg) - DIFF_W'(est_reg);
        dev_raw   = diff_raw[DIFF_W-1] ? DIFF_W'(-diff_raw) : DIFF_W'(diff_raw);
        spike_now = CMP_W'(dev_raw) > CMP_W'(max_jump_reg);
    end

    // Ramp and noise blend terms
    always_comb
    begin
        ramp_num   = dev_reg - adapt_start_reg;
        ramp_den   = adapt_full_reg - adapt_start_reg;
        q_up       = q_max_reg >= q_min_reg;
        r_down     = r_max_reg >= r_min_reg;
        q_span     = q_up ? q_max_reg - q_min_reg : q_min_reg - q_max_reg;
        r_span     = r_down ? r_max_reg - r_min_reg : r_min_reg - r_max_reg;
        blend_step = prod_reg[VF +: NOISE_W];
        q_new      = q_up ? q_min_reg + blend_step : q_min_reg - blend_step;
        r_new      = r_down ? r_max_reg - blend_step : r_max_reg + blend_step;
    end

    assign status.adapt     = dev_reg > adapt_start_reg;
    assign status.ramp_full = (adapt_full_reg <= adapt_start_reg) || (ramp_num >= ramp_den);
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    // Shared multiplier: unsigned gain-format operand times signed operand
    always_comb
    begin
        mul_a = alpha_reg;
        mul_b = MB_W'(alpha_reg);
        case (cmd.mul_sel)
            MUL_ALPHA:
            begin
                mul_a = alpha_reg;
                mul_b = MB_W'(alpha_reg);
            end
            MUL_QSPAN:
            begin
                mul_a = prod_reg[VF +: GAIN_W];
                mul_b = MB_W'(q_span);
            end
            MUL_RSPAN:
            begin
                mul_a = a2_reg;
                mul_b = MB_W'(r_span);
            end
            MUL_GAIN:
            begin
                mul_a = k_reg;
                mul_b = MB_W'(diff_reg);
            end
            MUL_VAR:
            begin
                mul_a = GAIN_ONE - k_reg;
                mul_b = MB_W'(pn_reg);
            end
            default:
            begin
                mul_a = alpha_reg;
                mul_b = MB_W'(alpha_reg);
            end
        endcase
        mul_p = $signed({1'b0, mul_a}) * mul_b;
    end

    // Divider shared by the ramp and the gain
    assign div_start = cmd.div_alpha || cmd.div_k;
    assign div_num   = cmd.div_alpha ? DIV_NUM_W'(ramp_num) : pn_reg;
    assign div_den   = cmd.div_alpha ? DIV_DEN_W'(ramp_den) : den_reg;

    askf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_jump_reg    <= MAX_JUMP_RST;
            adapt_start_reg <= ADAPT_START_RST;
            adapt_full_reg  <= ADAPT_FULL_RST;
            q_min_reg       <= Q_MIN_RST;
            q_max_reg       <= Q_MAX_RST;
            r_min_reg       <= R_MIN_RST;
            r_max_reg       <= R_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_JUMP:    max_jump_reg    <= cfg_data[DEV_W-1:0];
                REG_ADAPT_START: adapt_start_reg <= cfg_data[DEV_W-1:0];
                REG_ADAPT_FULL:  adapt_full_reg  <= cfg_data[DEV_W-1:0];
                REG_Q_MIN:       q_min_reg       <= cfg_data[NOISE_W-1:0];
                REG_Q_MAX:       q_max_reg       <= cfg_data[NOISE_W-1:0];
                REG_R_MIN:       r_min_reg       <= cfg_data[NOISE_W-1:0];
                REG_R_MAX:       r_max_reg       <= cfg_data[NOISE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Filter state; restart reloads on the input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= EST_INIT;
            p_reg   <= '0;
            q_reg   <= VAR_W'(Q_MIN_RST);
            r_reg   <= VAR_W'(R_MAX_RST);
        end
        else
        begin
            if (cmd.load_in && restart)
            begin
                est_reg <= sample;
                p_reg   <= '0;
                q_reg   <= VAR_W'(q_min_reg);
                r_reg   <= VAR_W'(r_max_reg);
            end
            if (cmd.load_q)
                q_reg <= VAR_W'(q_new);
            if (cmd.load_r)
                r_reg <= VAR_W'(r_new);
            if (cmd.load_est)
                est_reg <= est_reg + prod_reg[VF +: SW];
            if (cmd.load_p)
                p_reg <= prod_reg[VF +: VAR_W];
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            meas_reg <= sample;
        if (cmd.load_dev)
        begin
            spike_reg <= spike_now;
            diff_reg  <= spike_now ? '0 : diff_raw;
            dev_reg   <= spike_now ? '0 : DEV_W'(dev_raw);
        end
        if (cmd.alpha_one)
            alpha_reg <= GAIN_ONE;
        else if (cmd.load_alpha)
            alpha_reg <= div_quot;
        if (cmd.load_a2)
            a2_reg <= prod_reg[VF +: GAIN_W];
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.load_pn)
        begin
            pn_reg  <= DIV_NUM_W'(p_reg) + DIV_NUM_W'(q_reg);
            den_reg <= DIV_DEN_W'(p_reg) + DIV_DEN_W'(q_reg) + DIV_DEN_W'(r_reg);
        end
        if (cmd.load_k)
            k_reg <= (den_reg == '0) ? '0 : div_quot;
        if (cmd.load_out)
        begin
            out_est_reg   <= est_reg;
            out_spike_reg <= spike_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign estimate       = out_est_reg;
    assign spike_rejected = out_spike_reg;

endmodule

// ----- design/askf_ctrl.sv -----
// Controller: sequences one sample through deviation, adaptation, gain and update.
module askf_ctrl
    import askf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  askf_status_t status,
    output askf_cmd_t    cmd
);

    askf_state_t state_reg;
    askf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DEV;
            ST_DEV:
                state_next = ST_RAMP;
            ST_RAMP:
                if (!status.adapt)
                    state_next = ST_PN;
                else if (status.ramp_full)
                    state_next = ST_SQ;
                else
                    state_next = ST_DIV_A;
            ST_DIV_A:
                if (status.div_done)
                    state_next = ST_SQ;
            ST_SQ:
                state_next = ST_QB;
            ST_QB:
                state_next = ST_RB;
            ST_RB:
                state_next = ST_RD;
            ST_RD:
                state_next = ST_PN;
            ST_PN:
                state_next = ST_DIV_K;
            ST_DIV_K:
                state_next = ST_K_WAIT;
            ST_K_WAIT:
                if (status.div_done)
                    state_next = ST_EST;
            ST_EST:
                state_next = ST_VAR;
            ST_VAR:
                state_next = ST_PUPD;
            ST_PUPD:
                state_next = ST_DONE;
            ST_DONE:
                if (status.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.mul_sel = MUL_ALPHA;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_DEV:
                cmd.load_dev = 1'b1;
            ST_RAMP:
            begin
                cmd.alpha_one = status.adapt && status.ramp_full;
                cmd.div_alpha = status.adapt && !status.ramp_full;
            end
            ST_DIV_A:
                cmd.load_alpha = status.div_done;
            ST_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ALPHA;
            end
            ST_QB:
            begin
                cmd.load_a2 = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_QSPAN;
            end
            ST_RB:
            begin
                cmd.load_q  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RSPAN;
            end
            ST_RD:
                cmd.load_r = 1'b1;
            ST_PN:
                cmd.load_pn = 1'b1;
            ST_DIV_K:
                cmd.div_k = 1'b1;
            ST_K_WAIT:
                cmd.load_k = status.div_done;
            ST_EST:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
            end
            ST_VAR:
            begin
                cmd.load_est = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_VAR;
            end
            ST_PUPD:
                cmd.load_p = 1'b1;
            ST_DONE:
                cmd.load_out = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule
